// File: rtl/core/ryuv_pkg.sv
// shared constants and types of the rgb to yuv 4:2:0 subsampler
`default_nettype none

package ryuv_pkg;

  // defaults for the top level parameters
  localparam int MAX_WIDTH_DEF = 2048;
  localparam int FRAC_BITS_DEF = 16;

  // config register widths and reset values
  localparam int CFG_W     = 12;
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_W-1:0] FRAME_WIDTH_RST  = 12'd640;
  localparam logic [CFG_W-1:0] FRAME_HEIGHT_RST = 12'd480;

  // row counter and its wrap limit
  localparam int ROW_W = 11;
  localparam logic [ROW_W:0] ROW_LIMIT = 12'd2048;

  // depth of the queue between front and back
  localparam int QUEUE_DEPTH = 4;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_WIDTH  = 2'd0,
    REG_FRAME_HEIGHT = 2'd1
  } ryuv_reg_e;

  // position class of one pixel inside its 2x2 block
  typedef struct packed {
    logic col_odd;
    logic row_odd;
  } ryuv_pos_t;

endpackage

`default_nettype wire

// File: rtl/core/ryuv_if.sv
// channel interfaces: pixel in, result out, config write
`default_nettype none

interface ryuv_pix_if;
  logic       valid;
  logic       ready;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;

  modport source (output valid, output red, output green, output blue, input ready);
  modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

interface ryuv_res_if;
  logic       valid;
  logic       ready;
  logic [7:0] luma;
  logic       chroma_valid;
  logic [7:0] cb_avg;
  logic [7:0] cr_avg;

  modport source (output valid, output luma, output chroma_valid, output cb_avg,
                  output cr_avg, input ready);
  modport sink   (input valid, input luma, input chroma_valid, input cb_avg,
                  input cr_avg, output ready);
endinterface

interface ryuv_cfg_if;
  import ryuv_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_W-1:0]     data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// File: rtl/core/ryuv_ram.sv
// generic single write port ram with registered read
`default_nettype none

module ryuv_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// File: rtl/core/ryuv_fifo.sv
// short register queue between front and back
`default_nettype none

module ryuv_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = ryuv_pkg::QUEUE_DEPTH,
  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int CNTW = $clog2(DEPTH + 1)
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire logic [WIDTH-1:0] in_data_i,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output logic      [WIDTH-1:0] out_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PW-1:0]    wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CNTW-1:0]  count_q, count_d;
  logic             push, pop;

  assign in_ready_o  = (count_q != CNTW'(DEPTH));
  assign out_valid_o = (count_q != '0);
  assign out_data_o  = mem_q[rptr_q];
  assign push        = in_valid_i && in_ready_o;
  assign pop         = out_valid_o && out_ready_i;

  always_comb begin
    wptr_d  = wptr_q;
    rptr_d  = rptr_q;
    count_d = count_q;
    if (push) begin
      wptr_d = (wptr_q == PW'(DEPTH - 1)) ? '0 : wptr_q + 1'b1;
    end
    if (pop) begin
      rptr_d = (rptr_q == PW'(DEPTH - 1)) ? '0 : rptr_q + 1'b1;
    end
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      wptr_q  <= wptr_d;
      rptr_q  <= rptr_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wptr_q] <= in_data_i;
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNTW'(DEPTH))
    else $error("queue count beyond depth");
  a_count_up: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push && !pop |=> count_q == $past(count_q) + 1'b1)
    else $error("queue count did not grow on push");
  a_ptr_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q == '0 |-> wptr_q == rptr_q)
    else $error("empty queue with pointers apart");
`endif

endmodule

`default_nettype wire

// File: rtl/core/ryuv_front.sv
// front: config registers, raster counters, pixel capture and color conversion
`default_nettype none

module ryuv_front #(
  parameter int MAX_WIDTH = ryuv_pkg::MAX_WIDTH_DEF,
  parameter int FRAC_BITS = ryuv_pkg::FRAC_BITS_DEF,
  localparam int CHW = FRAC_BITS + 8,
  localparam int LINE_DEPTH = MAX_WIDTH / 2,
  localparam int AW = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_we_i,
  input  wire logic [ryuv_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [ryuv_pkg::CFG_W-1:0]      cfg_data_i,
  input  wire logic                            pix_valid_i,
  output logic                                 pix_ready_o,
  input  wire logic [7:0]                      red_i,
  input  wire logic [7:0]                      green_i,
  input  wire logic [7:0]                      blue_i,
  output logic                                 item_valid_o,
  input  wire logic                            item_ready_i,
  output logic      [7:0]                      luma_o,
  output logic      [CHW-1:0]                  cb_o,
  output logic      [CHW-1:0]                  cr_o,
  output ryuv_pkg::ryuv_pos_t                  pos_o,
  output logic      [AW-1:0]                   idx_o
);

  import ryuv_pkg::*;

  localparam int CW   = $clog2(MAX_WIDTH);
  localparam int CMPW = (CW + 1 > CFG_W) ? CW + 1 : CFG_W;
  localparam int SW   = FRAC_BITS + 10;

  // weights: four-decimal value scaled by 2^FRAC_BITS, rounded
  localparam longint unsigned KY_R  = ((64'd2989 << FRAC_BITS) + 64'd5000) / 64'd10000;
  localparam longint unsigned KY_G  = ((64'd5866 << FRAC_BITS) + 64'd5000) / 64'd10000;
  localparam longint unsigned KY_B  = ((64'd1145 << FRAC_BITS) + 64'd5000) / 64'd10000;
  localparam longint unsigned KCB_R = ((64'd1688 << FRAC_BITS) + 64'd5000) / 64'd10000;
  localparam longint unsigned KCB_G = ((64'd3312 << FRAC_BITS) + 64'd5000) / 64'd10000;
  localparam longint unsigned KCB_B = ((64'd5000 << FRAC_BITS) + 64'd5000) / 64'd10000;
  localparam longint unsigned KCR_R = ((64'd5000 << FRAC_BITS) + 64'd5000) / 64'd10000;
  localparam longint unsigned KCR_G = ((64'd4184 << FRAC_BITS) + 64'd5000) / 64'd10000;
  localparam longint unsigned KCR_B = ((64'd816 << FRAC_BITS) + 64'd5000) / 64'd10000;
  localparam longint unsigned BIAS  = 64'd128 << FRAC_BITS;
  localparam longint unsigned TOP   = 64'd255 << FRAC_BITS;

  logic [CFG_W-1:0] fw_q, fh_q;
  logic [CW-1:0]    col_q, col_d;
  logic [ROW_W-1:0] row_q, row_d;
  logic [CW:0]      col_inc;
  logic [ROW_W:0]   row_inc;
  logic             col_wrap, row_wrap;
  logic             accept;

  logic             f_valid_q;
  logic [7:0]       f_red_q, f_green_q, f_blue_q;
  ryuv_pos_t        f_pos_q;
  logic [AW-1:0]    f_idx_q;

  logic [SW-1:0]    y_sum, cb_raw, cr_raw;
  logic [SW-1:0]    r_ext, g_ext, b_ext;
  logic [SW-FRAC_BITS-1:0] y_int;

  // config writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fw_q <= FRAME_WIDTH_RST;
      fh_q <= FRAME_HEIGHT_RST;
    end else if (cfg_we_i) begin
      case (ryuv_reg_e'(cfg_idx_i))
        REG_FRAME_WIDTH:  fw_q <= cfg_data_i;
        REG_FRAME_HEIGHT: fh_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign pix_ready_o = !f_valid_q || item_ready_i;
  assign accept      = pix_valid_i && pix_ready_o;

  // column wraps at the smaller of frame width and max width, row likewise
  always_comb begin
    col_inc = {1'b0, col_q} + 1'b1;
    row_inc = {1'b0, row_q} + 1'b1;
    if (CMPW'(fw_q) >= CMPW'(MAX_WIDTH)) begin
      col_wrap = (CMPW'(col_inc) >= CMPW'(MAX_WIDTH));
    end else begin
      col_wrap = (CMPW'(col_inc) >= CMPW'(fw_q));
    end
    if ((ROW_W + 1)'(fh_q) >= ROW_LIMIT) begin
      row_wrap = (row_inc >= ROW_LIMIT);
    end else begin
      row_wrap = (row_inc >= (ROW_W + 1)'(fh_q));
    end
    col_d = col_q;
    row_d = row_q;
    if (accept) begin
      if (col_wrap) begin
        col_d = '0;
        row_d = row_wrap ? '0 : row_inc[ROW_W-1:0];
      end else begin
        col_d = col_inc[CW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q     <= '0;
      row_q     <= '0;
      f_valid_q <= 1'b0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
      if (accept) begin
        f_valid_q <= 1'b1;
      end else if (item_ready_i) begin
        f_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      f_red_q         <= red_i;
      f_green_q       <= green_i;
      f_blue_q        <= blue_i;
      f_pos_q.col_odd <= col_q[0];
      f_pos_q.row_odd <= row_q[0];
      f_idx_q         <= AW'(col_q >> 1);
    end
  end

  // constant-weight products, sums kept modulo 2^SW, chroma read as signed
  always_comb begin
    r_ext  = SW'(f_red_q);
    g_ext  = SW'(f_green_q);
    b_ext  = SW'(f_blue_q);
    y_sum  = SW'(KY_R) * r_ext + SW'(KY_G) * g_ext + SW'(KY_B) * b_ext;
    cb_raw = SW'(BIAS) - SW'(KCB_R) * r_ext - SW'(KCB_G) * g_ext + SW'(KCB_B) * b_ext;
    cr_raw = SW'(BIAS) + SW'(KCR_R) * r_ext - SW'(KCR_G) * g_ext - SW'(KCR_B) * b_ext;
    y_int  = y_sum[SW-1:FRAC_BITS];

    luma_o = (y_int > (SW - FRAC_BITS)'(255)) ? 8'hff : y_int[7:0];

    if (cb_raw[SW-1]) begin
      cb_o = '0;
    end else if (cb_raw > SW'(TOP)) begin
      cb_o = CHW'(TOP);
    end else begin
      cb_o = cb_raw[CHW-1:0];
    end

    if (cr_raw[SW-1]) begin
      cr_o = '0;
    end else if (cr_raw > SW'(TOP)) begin
      cr_o = CHW'(TOP);
    end else begin
      cr_o = cr_raw[CHW-1:0];
    end
  end

  assign item_valid_o = f_valid_q;
  assign pos_o        = f_pos_q;
  assign idx_o        = f_idx_q;

endmodule

`default_nettype wire

// File: rtl/core/ryuv_back.sv
// back: horizontal pairing, chroma line store and 2x2 averaging
`default_nettype none

module ryuv_back #(
  parameter int MAX_WIDTH = ryuv_pkg::MAX_WIDTH_DEF,
  parameter int FRAC_BITS = ryuv_pkg::FRAC_BITS_DEF,
  localparam int CHW = FRAC_BITS + 8,
  localparam int LINE_DEPTH = MAX_WIDTH / 2,
  localparam int AW = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 item_valid_i,
  output logic                      item_ready_o,
  input  wire logic [7:0]           luma_i,
  input  wire logic [CHW-1:0]       cb_i,
  input  wire logic [CHW-1:0]       cr_i,
  input  wire ryuv_pkg::ryuv_pos_t  pos_i,
  input  wire logic [AW-1:0]        idx_i,
  output logic                      res_valid_o,
  input  wire logic                 res_ready_i,
  output logic      [7:0]           luma_o,
  output logic                      chroma_valid_o,
  output logic      [7:0]           cb_avg_o,
  output logic      [7:0]           cr_avg_o
);

  import ryuv_pkg::*;

  localparam int PW = CHW + 1;

  logic             pop, out_load;
  logic [CHW-1:0]   left_cb_q, left_cr_q;
  logic [PW-1:0]    pair_cb, pair_cr;

  logic             ram_we, ram_re;
  logic [2*PW-1:0]  ram_rdata;
  logic [PW-1:0]    above_cb, above_cr;

  logic             s1_valid_q;
  logic [7:0]       s1_luma_q;
  logic             s1_emit_q;
  logic [PW-1:0]    s1_pcb_q, s1_pcr_q;

  logic [PW:0]      sum_cb, sum_cr;

  logic             o_valid_q;
  logic [7:0]       o_luma_q, o_cb_q, o_cr_q;
  logic             o_cv_q;

  assign out_load     = s1_valid_q && (!o_valid_q || res_ready_i);
  assign item_ready_o = !s1_valid_q || out_load;
  assign pop          = item_valid_i && item_ready_o;

  assign pair_cb = PW'(left_cb_q) + PW'(cb_i);
  assign pair_cr = PW'(left_cr_q) + PW'(cr_i);

  // even rows store pair sums, odd rows fetch the pair from the row above
  assign ram_we = pop && pos_i.col_odd && !pos_i.row_odd;
  assign ram_re = pop && pos_i.col_odd && pos_i.row_odd;

  ryuv_ram #(
    .WIDTH (2 * PW),
    .DEPTH (LINE_DEPTH)
  ) u_line_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (idx_i),
    .wdata_i ({pair_cb, pair_cr}),
    .re_i    (ram_re),
    .raddr_i (idx_i),
    .rdata_o (ram_rdata)
  );

  assign above_cb = ram_rdata[2*PW-1:PW];
  assign above_cr = ram_rdata[PW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_cb_q  <= '0;
      left_cr_q  <= '0;
      s1_valid_q <= 1'b0;
      o_valid_q  <= 1'b0;
    end else begin
      if (pop && !pos_i.col_odd) begin
        left_cb_q <= cb_i;
        left_cr_q <= cr_i;
      end
      if (pop) begin
        s1_valid_q <= 1'b1;
      end else if (out_load) begin
        s1_valid_q <= 1'b0;
      end
      if (out_load) begin
        o_valid_q <= 1'b1;
      end else if (res_ready_i) begin
        o_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      s1_luma_q <= luma_i;
      s1_emit_q <= pos_i.col_odd && pos_i.row_odd;
      s1_pcb_q  <= pair_cb;
      s1_pcr_q  <= pair_cr;
    end
  end

  assign sum_cb = (PW + 1)'(above_cb) + (PW + 1)'(s1_pcb_q);
  assign sum_cr = (PW + 1)'(above_cr) + (PW + 1)'(s1_pcr_q);

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      o_luma_q <= s1_luma_q;
      o_cv_q   <= s1_emit_q;
      o_cb_q   <= s1_emit_q ? sum_cb[PW:FRAC_BITS+2] : 8'd0;
      o_cr_q   <= s1_emit_q ? sum_cr[PW:FRAC_BITS+2] : 8'd0;
    end
  end

  assign res_valid_o    = o_valid_q;
  assign luma_o         = o_luma_q;
  assign chroma_valid_o = o_cv_q;
  assign cb_avg_o       = o_cb_q;
  assign cr_avg_o       = o_cr_q;

`ifndef SYNTHESIS
  a_no_rw_same_cycle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ram_we && ram_re))
    else $error("line store read and write in one cycle");
  a_s1_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !out_load |=> s1_valid_q && $stable(s1_pcb_q) && $stable(s1_emit_q))
    else $error("pairing stage lost a stalled word");
  a_no_chroma_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    o_valid_q && !o_cv_q |-> o_cb_q == 8'd0 && o_cr_q == 8'd0)
    else $error("chroma fields nonzero without chroma valid");
`endif

endmodule

`default_nettype wire

// File: rtl/core/rgb_to_yuv420_subsampler.sv
// top level: rgb pixel stream to luma plus 2x2 averaged chroma
//
//   channel  dir  payload                              handshake
//   pix_i    in   red, green, blue                     valid/ready
//   res_o    out  luma, chroma_valid, cb_avg, cr_avg   valid/ready
//   cfg_i    in   index, data (frame_width/height)     valid/ready, ready always high
//
// one pixel per clock sustained while res_o is ready
// the line store takes at most one read or one write per pixel, which sets that rate
// reset clears counters and valid flags; the line store holds no reset value
// a stalled result holds in the output register while the queue keeps filling
`default_nettype none

module rgb_to_yuv420_subsampler #(
  parameter int MAX_WIDTH = ryuv_pkg::MAX_WIDTH_DEF,
  parameter int FRAC_BITS = ryuv_pkg::FRAC_BITS_DEF
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  ryuv_cfg_if.sink   cfg_i,
  ryuv_pix_if.sink   pix_i,
  ryuv_res_if.source res_o
);

  import ryuv_pkg::*;

  localparam int CHW        = FRAC_BITS + 8;
  localparam int LINE_DEPTH = MAX_WIDTH / 2;
  localparam int AW         = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
  localparam int QW         = 8 + 2 * CHW + $bits(ryuv_pos_t) + AW;

  logic           f_valid, f_ready;
  logic [7:0]     f_luma;
  logic [CHW-1:0] f_cb, f_cr;
  ryuv_pos_t      f_pos;
  logic [AW-1:0]  f_idx;

  logic           q_valid, q_ready;
  logic [QW-1:0]  q_data;
  logic [7:0]     q_luma;
  logic [CHW-1:0] q_cb, q_cr;
  ryuv_pos_t      q_pos;
  logic [AW-1:0]  q_idx;

  assign cfg_i.ready = 1'b1;

  ryuv_front #(
    .MAX_WIDTH (MAX_WIDTH),
    .FRAC_BITS (FRAC_BITS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_i.valid),
    .cfg_idx_i    (cfg_i.index),
    .cfg_data_i   (cfg_i.data),
    .pix_valid_i  (pix_i.valid),
    .pix_ready_o  (pix_i.ready),
    .red_i        (pix_i.red),
    .green_i      (pix_i.green),
    .blue_i       (pix_i.blue),
    .item_valid_o (f_valid),
    .item_ready_i (f_ready),
    .luma_o       (f_luma),
    .cb_o         (f_cb),
    .cr_o         (f_cr),
    .pos_o        (f_pos),
    .idx_o        (f_idx)
  );

  ryuv_fifo #(
    .WIDTH (QW),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (f_valid),
    .in_ready_o  (f_ready),
    .in_data_i   ({f_luma, f_cb, f_cr, f_pos, f_idx}),
    .out_valid_o (q_valid),
    .out_ready_i (q_ready),
    .out_data_o  (q_data)
  );

  assign {q_luma, q_cb, q_cr, q_pos, q_idx} = q_data;

  ryuv_back #(
    .MAX_WIDTH (MAX_WIDTH),
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .item_valid_i   (q_valid),
    .item_ready_o   (q_ready),
    .luma_i         (q_luma),
    .cb_i           (q_cb),
    .cr_i           (q_cr),
    .pos_i          (q_pos),
    .idx_i          (q_idx),
    .res_valid_o    (res_o.valid),
    .res_ready_i    (res_o.ready),
    .luma_o         (res_o.luma),
    .chroma_valid_o (res_o.chroma_valid),
    .cb_avg_o       (res_o.cb_avg),
    .cr_avg_o       (res_o.cr_avg)
  );

endmodule

`default_nettype wire

// File: tb/sv/rgb_to_yuv420_subsampler_tb.sv
// self-checking testbench of the rgb to yuv 4:2:0 subsampler with a bit-exact predictor
module rgb_to_yuv420_subsampler_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ryuv_pkg::*;

  localparam int FRAC       = FRAC_BITS_DEF;
  localparam int LINE_PAIRS = MAX_WIDTH_DEF / 2;

  // full-range ycbcr weights scaled by 2^16
  localparam longint Y_R  = 19589;
  localparam longint Y_G  = 38443;
  localparam longint Y_B  = 7504;
  localparam longint CB_R = 11062;
  localparam longint CB_G = 21706;
  localparam longint CB_B = 32768;
  localparam longint CR_R = 32768;
  localparam longint CR_G = 27420;
  localparam longint CR_B = 5348;
  localparam longint CHROMA_BIAS = longint'(128) << FRAC;
  localparam longint CHROMA_TOP  = longint'(255) << FRAC;

  localparam int DRAIN_CYCLES = 12;
  localparam int STALL_LIMIT  = 2000;

  typedef struct packed {
    logic [7:0] luma;
    logic       chroma_valid;
    logic [7:0] cb_avg;
    logic [7:0] cr_avg;
  } yuv_word_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  ryuv_pix_if pix_ch ();
  ryuv_res_if res_ch ();
  ryuv_cfg_if cfg_ch ();

  rgb_to_yuv420_subsampler u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_ch),
    .pix_i  (pix_ch),
    .res_o  (res_ch)
  );

  always #5 clk_i = ~clk_i;

  // predictor state
  logic [CFG_W-1:0] frame_width_q  = FRAME_WIDTH_RST;
  logic [CFG_W-1:0] frame_height_q = FRAME_HEIGHT_RST;
  int unsigned       col_pos = 0;
  int unsigned       row_pos = 0;
  longint unsigned   left_cb = 0;
  longint unsigned   left_cr = 0;
  longint unsigned   pair_cb [LINE_PAIRS];
  longint unsigned   pair_cr [LINE_PAIRS];

  yuv_word_t expected_words[$];
  int        error_count  = 0;
  int        stall_cycles = 0;
  int        src_idle_pct = 0;
  int        snk_idle_pct = 0;

  function automatic longint clamp_chroma(input longint v);
    if (v < 0) return 0;
    if (v > CHROMA_TOP) return CHROMA_TOP;
    return v;
  endfunction

  function automatic yuv_word_t convert_pixel(input logic [7:0] red, green, blue);
    longint          r, g, b, y_acc, cb, cr;
    longint unsigned cb_sum, cr_sum;
    int unsigned     wlim, hlim, idx;
    yuv_word_t       w;
    r = red;
    g = green;
    b = blue;
    y_acc = Y_R * r + Y_G * g + Y_B * b;
    cb = clamp_chroma(CHROMA_BIAS - CB_R * r - CB_G * g + CB_B * b);
    cr = clamp_chroma(CHROMA_BIAS + CR_R * r - CR_G * g - CR_B * b);
    w = '0;
    w.luma = ((y_acc >>> FRAC) > 255) ? 8'd255 : 8'(y_acc >>> FRAC);
    wlim = (frame_width_q < MAX_WIDTH_DEF) ? frame_width_q : MAX_WIDTH_DEF;
    hlim = (frame_height_q < ROW_LIMIT) ? frame_height_q : ROW_LIMIT;
    if (col_pos % 2 == 0) begin
      left_cb = cb;
      left_cr = cr;
    end else begin
      idx = (col_pos / 2) % LINE_PAIRS;
      cb_sum = left_cb + cb;
      cr_sum = left_cr + cr;
      if (row_pos % 2 == 0) begin
        pair_cb[idx] = cb_sum;
        pair_cr[idx] = cr_sum;
      end else begin
        w.chroma_valid = 1'b1;
        w.cb_avg = 8'((pair_cb[idx] + cb_sum) >> (FRAC + 2));
        w.cr_avg = 8'((pair_cr[idx] + cr_sum) >> (FRAC + 2));
      end
    end
    // counters wrap after this pixel, also when already past a shrunk limit
    if (col_pos + 1 >= wlim) begin
      col_pos = 0;
      row_pos = (row_pos + 1 >= hlim) ? 0 : row_pos + 1;
    end else begin
      col_pos++;
    end
    return w;
  endfunction

  function automatic logic [7:0] random_level();
    case ($urandom_range(7, 0))
      0:       return 8'h00;
      1:       return 8'hff;
      default: return 8'($urandom_range(255, 0));
    endcase
  endfunction

  function automatic logic [CFG_W-1:0] random_extent(input int unsigned most);
    case ($urandom_range(9, 0))
      0:       return CFG_W'($urandom_range(1, 0));
      1:       return CFG_W'(2 * $urandom_range(most / 2, 1) + 1);
      default: return CFG_W'(2 * $urandom_range(most / 2, 1));
    endcase
  endfunction

  // starts and ends at a falling edge; valid stays high for a following word
  task automatic send_pixel(input logic [7:0] red, green, blue);
    while ($urandom_range(99, 0) < src_idle_pct) begin
      pix_ch.valid <= 1'b0;
      @(negedge clk_i);
    end
    pix_ch.valid <= 1'b1;
    pix_ch.red   <= red;
    pix_ch.green <= green;
    pix_ch.blue  <= blue;
    do @(posedge clk_i); while (!pix_ch.ready);
    expected_words.push_back(convert_pixel(red, green, blue));
    @(negedge clk_i);
  endtask

  task automatic send_random_pixels(input int count);
    repeat (count) send_pixel(random_level(), random_level(), random_level());
  endtask

  task automatic wait_for_results();
    pix_ch.valid <= 1'b0;
    @(negedge clk_i);
    while (expected_words.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  // resize only on an even row, so every line store entry an odd row reads was written
  task automatic set_frame_size(input logic [CFG_W-1:0] width, height);
    while (row_pos % 2 != 0) send_random_pixels(1);
    wait_for_results();
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= REG_FRAME_WIDTH;
    cfg_ch.data  <= width;
    do @(posedge clk_i); while (!cfg_ch.ready);
    frame_width_q = width;
    @(negedge clk_i);
    cfg_ch.index <= REG_FRAME_HEIGHT;
    cfg_ch.data  <= height;
    do @(posedge clk_i); while (!cfg_ch.ready);
    frame_height_q = height;
    @(negedge clk_i);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic test_color_extremes();
    logic [23:0] swatch [16];
    // red, blue, yellow, cyan, black, white and mixes; pure red and blue saturate chroma
    swatch = '{24'h000000, 24'hffffff, 24'hff0000, 24'hff0000,
               24'h0000ff, 24'h0000ff, 24'hffff00, 24'h00ffff,
               24'hffffff, 24'h000000, 24'hff0000, 24'hff0000,
               24'h0000ff, 24'h0000ff, 24'h55aa80, 24'haa557f};
    set_frame_size(12'd8, 12'd2);
    foreach (swatch[i]) send_pixel(swatch[i][23:16], swatch[i][15:8], swatch[i][7:0]);
  endtask

  task automatic test_odd_and_degenerate_sizes();
    set_frame_size(12'd5, 12'd3);
    send_random_pixels(30);
    // zero or one keeps that counter at zero
    set_frame_size(12'd0, 12'd5);
    send_random_pixels(7);
    set_frame_size(12'd1, 12'd0);
    send_random_pixels(3);
    set_frame_size(12'd6, 12'd1);
    send_random_pixels(12);
    set_frame_size(12'd7, 12'd4);
    send_random_pixels(28);
  endtask

  task automatic test_midframe_resize();
    set_frame_size(12'd8, 12'd4);
    send_random_pixels(20);
    // column already at the new width, wraps after the next pixel
    set_frame_size(12'd4, 12'd4);
    send_random_pixels(16);
    // widen inside a row that is already past the new height
    set_frame_size(12'd16, 12'd2);
    send_random_pixels(30);
  endtask

  task automatic test_random_frames(input int pixel_count);
    int sent;
    int burst;
    sent = 0;
    while (sent < pixel_count) begin
      if ($urandom_range(3, 0) == 0) set_frame_size(random_extent(24), random_extent(10));
      burst = $urandom_range(40, 1);
      send_random_pixels(burst);
      sent += burst;
      // hold the sender until the pipeline has emptied
      if ($urandom_range(9, 0) == 0) wait_for_results();
    end
    wait_for_results();
  endtask

  task automatic test_widest_line();
    // width past the line limit counts as the widest line
    set_frame_size(12'd4095, 12'd2);
    send_random_pixels(120);
  endtask

  task automatic test_tallest_frame();
    // height past the row limit, one pixel per line
    set_frame_size(12'd1, 12'd4095);
    send_random_pixels(120);
  endtask

  task automatic compare_field(input string name, input logic [7:0] want, got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      error_count++;
    end
  endtask

  always @(negedge clk_i) res_ch.ready <= ($urandom_range(99, 0) >= snk_idle_pct);

  always @(posedge clk_i) begin : check_results
    yuv_word_t want;
    if (rst_ni && res_ch.valid && res_ch.ready) begin
      if (expected_words.size() == 0) begin
        $display("%0t: result word with no pixel pending, expected none, got luma %0d",
                 $time, res_ch.luma);
        error_count++;
      end else begin
        want = expected_words.pop_front();
        compare_field("luma", want.luma, res_ch.luma);
        compare_field("chroma_valid", 8'(want.chroma_valid), 8'(res_ch.chroma_valid));
        compare_field("cb_avg", want.cb_avg, res_ch.cb_avg);
        compare_field("cr_avg", want.cr_avg, res_ch.cr_avg);
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (pix_ch.valid && pix_ch.ready) || (res_ch.valid && res_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("%0t: no word moved for %0d cycles", $time, STALL_LIMIT);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    pix_ch.valid = 1'b0;
    pix_ch.red   = '0;
    pix_ch.green = '0;
    pix_ch.blue  = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = REG_FRAME_WIDTH;
    cfg_ch.data  = '0;
    src_idle_pct = 32;
    snk_idle_pct = 85;
    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_color_extremes();
    test_odd_and_degenerate_sizes();
    test_midframe_resize();
    test_random_frames(150);

    src_idle_pct = 85;
    snk_idle_pct = 32;
    test_random_frames(150);

    src_idle_pct = 0;
    snk_idle_pct = 0;
    test_random_frames(100);
    test_widest_line();
    test_tallest_frame();

    wait_for_results();
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/core/ryuv_pkg.sv
rtl/core/ryuv_if.sv
rtl/core/ryuv_ram.sv
rtl/core/ryuv_fifo.sv
rtl/core/ryuv_front.sv
rtl/core/ryuv_back.sv
rtl/core/rgb_to_yuv420_subsampler.sv
tb/sv/rgb_to_yuv420_subsampler_tb.sv
